>>> design/bsot_pkg.sv
// Shared types, constants and helpers for the box significance octant test.
// No dependencies; every other design file imports this package.
package bsot_pkg;

    localparam int MAX_DIM    = 64;
    localparam int COORD_W    = $clog2(MAX_DIM);
    localparam int LEN_W      = COORD_W + 1;
    localparam int DIM_W      = 7;
    localparam int ROW_AW     = 2 * COORD_W;
    localparam int ROWS       = MAX_DIM * MAX_DIM;
    localparam int IN_DATA_W  = ((3 * COORD_W + 3 * LEN_W + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TEST  = 1'b1
    } t_cmd;

    // effective (clamped) volume extents
    typedef struct packed {
        logic [LEN_W-1:0] x;
        logic [LEN_W-1:0] y;
        logic [LEN_W-1:0] z;
    } t_dims;

    // classified item handed from the front to the back
    typedef struct packed {
        t_cmd                 cmd;
        logic                 map_bit;
        logic                 wr_ok;
        logic                 empty;
        logic [COORD_W-1:0]   sx;
        logic [COORD_W-1:0]   sy;
        logic [COORD_W-1:0]   sz;
        logic [LEN_W-1:0]     ey;
        logic [LEN_W-1:0]     ez;
        logic [LEN_W-1:0]     uy;
        logic [LEN_W-1:0]     uz;
        logic [MAX_DIM-1:0]   xlo;
        logic [MAX_DIM-1:0]   xhi;
    } t_job;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_WR_RD,
        ST_WR_WR,
        ST_DONE
    } t_back_state;

    function automatic logic [LEN_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [LEN_W-1:0] r;
        if (d > DIM_W'(MAX_DIM)) begin
            r = LEN_W'(MAX_DIM);
        end else begin
            r = LEN_W'(d);
        end
        return r;
    endfunction

endpackage

>>> design/bsot_front.sv
// Input side: takes stream transfers and classifies them into jobs.
// Depends on bsot_pkg.
module bsot_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bsot_pkg::t_dims               i_dims,
    input  logic                          i_hold,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bsot_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output bsot_pkg::t_job                o_push_job
);
    import bsot_pkg::*;

    logic               r_valid;
    t_job               r_job;
    t_job               n_job;
    logic               accept;
    logic [COORD_W-1:0] sx, sy, sz;
    logic [LEN_W-1:0]   lx, ly, lz;
    // box ends and half-split points need one bit more than a length
    logic [LEN_W:0]     ex, ey, ez, ux, uy, uz;

    assign sx = s_axis_tdata[0 +: COORD_W];
    assign sy = s_axis_tdata[COORD_W +: COORD_W];
    assign sz = s_axis_tdata[2 * COORD_W +: COORD_W];
    assign lx = s_axis_tdata[3 * COORD_W +: LEN_W];
    assign ly = s_axis_tdata[3 * COORD_W + LEN_W +: LEN_W];
    assign lz = s_axis_tdata[3 * COORD_W + 2 * LEN_W +: LEN_W];

    assign ex = {2'b0, sx} + {1'b0, lx};
    assign ey = {2'b0, sy} + {1'b0, ly};
    assign ez = {2'b0, sz} + {1'b0, lz};
    assign ux = ex - {2'b0, lx[LEN_W-1:1]};
    assign uy = ey - {2'b0, ly[LEN_W-1:1]};
    assign uz = ez - {2'b0, lz[LEN_W-1:1]};

    assign s_axis_tready = !i_hold && (!r_valid || i_push_ready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_push_valid  = r_valid;
    assign o_push_job    = r_job;

    always_comb begin
        n_job         = '0;
        n_job.cmd     = t_cmd'(s_axis_tuser);
        n_job.map_bit = s_axis_tdata[3 * COORD_W + 3 * LEN_W];
        n_job.wr_ok   = ({1'b0, sx} < i_dims.x) && ({1'b0, sy} < i_dims.y)
                        && ({1'b0, sz} < i_dims.z);
        n_job.empty   = (lx == '0) || (ly == '0) || (lz == '0);
        n_job.sx      = sx;
        n_job.sy      = sy;
        n_job.sz      = sz;
        // rows past the cube are clear, so the scan stops at its edge
        n_job.ey      = (ey > (LEN_W+1)'(MAX_DIM)) ? LEN_W'(MAX_DIM) : ey[LEN_W-1:0];
        n_job.ez      = (ez > (LEN_W+1)'(MAX_DIM)) ? LEN_W'(MAX_DIM) : ez[LEN_W-1:0];
        n_job.uy      = uy[LEN_W-1:0];
        n_job.uz      = uz[LEN_W-1:0];
        // per-column masks for the lower and upper x halves, clipped to the volume
        for (int i = 0; i < MAX_DIM; i++) begin
            n_job.xlo[i] = ((LEN_W+1)'(i) >= {2'b0, sx}) && ((LEN_W+1)'(i) < ex)
                           && ((LEN_W+1)'(i) < {1'b0, i_dims.x}) && ((LEN_W+1)'(i) < ux);
            n_job.xhi[i] = ((LEN_W+1)'(i) >= {2'b0, sx}) && ((LEN_W+1)'(i) < ex)
                           && ((LEN_W+1)'(i) < {1'b0, i_dims.x}) && ((LEN_W+1)'(i) >= ux);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

>>> design/bsot_queue.sv
// Two-entry job queue between the front and the back.
// Depends on bsot_pkg.
module bsot_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bsot_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bsot_pkg::t_job o_pop_job
);
    import bsot_pkg::*;

    t_job       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_job    = r_buf[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_push_job;
        end
    end

endmodule

>>> design/bsot_back.sv
// Back end: significance map memory (one x row per word), box scan engine,
// bit write by read-modify-write, post-reset clearing pass and result register.
// Depends on bsot_pkg.
module bsot_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bsot_pkg::t_dims                i_dims,
    output logic                           o_clearing,
    input  logic                           i_pop_valid,
    output logic                           o_pop_ready,
    input  bsot_pkg::t_job                 i_pop_job,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [bsot_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bsot_pkg::*;

    logic [MAX_DIM-1:0] r_mem [ROWS];
    logic [MAX_DIM-1:0] r_rd_data;

    t_back_state        r_state, n_state;
    t_job               r_job;
    logic [LEN_W-1:0]   r_y, r_z;
    logic [ROW_AW-1:0]  r_clr;
    logic               r_rd_pend;
    logic               r_yh, r_zh;
    logic [7:0]         r_mask;
    logic               r_out_valid;
    logic [7:0]         r_out_mask;

    logic [LEN_W-1:0]   y_next, z_next;
    logic               y_wrap, last_row, row_ok, pop, out_load;
    logic               mem_we, mem_re;
    logic [ROW_AW-1:0]  mem_wa, mem_ra;
    logic [MAX_DIM-1:0] mem_wd, row_mod;
    logic               lo_hit, hi_hit;
    logic [7:0]         hit_mask;

    assign y_next   = r_y + LEN_W'(1);
    assign z_next   = r_z + LEN_W'(1);
    assign y_wrap   = (y_next == r_job.ey);
    assign last_row = y_wrap && (z_next == r_job.ez);
    assign row_ok   = (r_y < i_dims.y) && (r_z < i_dims.z);
    assign pop      = i_pop_valid && o_pop_ready;

    assign lo_hit   = |(r_rd_data & r_job.xlo);
    assign hi_hit   = |(r_rd_data & r_job.xhi);
    assign hit_mask = {6'd0, hi_hit, lo_hit} << {r_zh, r_yh, 1'b0};

    always_comb begin
        row_mod               = r_rd_data;
        row_mod[r_job.sx]     = r_job.map_bit;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_pop_valid) begin
                    if (i_pop_job.cmd == CMD_TEST) begin
                        n_state = i_pop_job.empty ? ST_DONE : ST_SCAN;
                    end else if (i_pop_job.wr_ok) begin
                        n_state = ST_WR_RD;
                    end
                end
            end
            ST_SCAN: begin
                if (last_row) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: n_state = ST_DONE;
            ST_WR_RD: n_state = ST_WR_WR;
            ST_WR_WR: n_state = ST_IDLE;
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_pop_ready = 1'b0;
        o_clearing  = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = {r_job.sz, r_job.sy};
        mem_wd      = row_mod;
        mem_re      = 1'b0;
        mem_ra      = {r_job.sz, r_job.sy};
        out_load    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_clearing = 1'b1;
                mem_we     = 1'b1;
                mem_wa     = r_clr;
                mem_wd     = '0;
            end
            ST_IDLE:  o_pop_ready = 1'b1;
            ST_SCAN: begin
                mem_re = row_ok;
                mem_ra = {r_z[COORD_W-1:0], r_y[COORD_W-1:0]};
            end
            ST_WR_RD: mem_re = 1'b1;
            ST_WR_WR: mem_we = 1'b1;
            ST_DONE:  out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == ST_SCAN) && row_ok;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ROW_AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job  <= i_pop_job;
            r_y    <= {1'b0, i_pop_job.sy};
            r_z    <= {1'b0, i_pop_job.sz};
            r_mask <= '0;
        end else if (r_rd_pend) begin
            r_mask <= r_mask | hit_mask;
        end
        if (r_state == ST_SCAN) begin
            r_yh <= (r_y >= r_job.uy);
            r_zh <= (r_z >= r_job.uz);
            if (y_wrap) begin
                r_y <= {1'b0, r_job.sy};
                r_z <= z_next;
            end else begin
                r_y <= y_next;
            end
        end
        if (out_load) begin
            r_out_mask <= r_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_mask, |r_out_mask};

endmodule

>>> design/box_significance_octant_test.sv
// Top level of the box significance octant test.
// Depends on bsot_pkg, bsot_front, bsot_queue and bsot_back.
//
// Holds a 64x64x64 one-bit significance map. Items arrive on the slave stream:
// tuser = 0 writes one map bit, tuser = 1 tests a box and gives one result
// transfer on the master stream (set flag and 8-bit octant mask). Writes give
// no result. Extents come from three configuration registers (reset 64).
//
// Front end registers and classifies each transfer (half-split points, x column
// masks, clipping against the extents), a two-entry queue decouples it from the
// back end, which owns the map memory, one 64-bit x row per word.
// Per item in the back end: a box test scans the y/z rows of the box inside
// the cube one after another, reads those inside the volume and ORs their hits
// into the octant mask; an empty box gives an all-zero result without a scan; a
// write inside the volume reads, modifies and writes back one map row, and one
// outside the volume is dropped.
// Reset: synchronous, active low. Afterwards the map is cleared row by row;
// s_axis_tready stays low meanwhile, configuration writes are taken as usual.
// A stalled result holds in the output register; the back end finishes the
// next test and waits, while the queue keeps taking items until it is full.
module box_significance_octant_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [bsot_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bsot_pkg::DIM_W-1:0]      i_cfg_data,
    // item input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_x, start_y, start_z, len_x, len_y, len_z, map_bit
    input  logic [bsot_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // command
    input  logic                            s_axis_tuser,
    // result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // set_significant, octant_mask, zero fill
    output logic [bsot_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import bsot_pkg::*;

    logic [DIM_W-1:0] r_dim_x, r_dim_y, r_dim_z;
    t_dims            dims;
    logic             clearing;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    t_job             push_job, pop_job;

    // extents above the map size act as the map size
    assign dims.x = eff_dim(r_dim_x);
    assign dims.y = eff_dim(r_dim_y);
    assign dims.z = eff_dim(r_dim_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DIM_W'(MAX_DIM);
            r_dim_y <= DIM_W'(MAX_DIM);
            r_dim_z <= DIM_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DIM_X: r_dim_x <= i_cfg_data;
                CFG_DIM_Y: r_dim_y <= i_cfg_data;
                CFG_DIM_Z: r_dim_z <= i_cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    bsot_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dims        (dims),
        .i_hold        (clearing),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_job    (push_job)
    );

    bsot_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    bsot_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dims        (dims),
        .o_clearing    (clearing),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_job     (pop_job),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
